// ----- hdl/sdr_pkg.sv -----
// Shared widths, register indexes and reset values for the stick deadzone core.
// No dependencies; every other file in hdl/ imports this package.
package sdr_pkg;

  localparam int AX_W      = 16;          // signed axis sample width
  localparam int CFG_W     = 15;          // widest configuration register
  localparam int CFG_IDX_W = 3;           // configuration register index width
  localparam int SQ_W      = 32;          // sum of squares of three axes
  localparam int MAG_W     = SQ_W / 2;    // integer square root width
  localparam int REM_W     = MAG_W + 1;   // square root partial remainder

  localparam logic [CFG_W-1:0] DZ_RESET    = 15'd819;
  localparam logic [CFG_W-1:0] UPPER_RESET = 15'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVE_DZ   = 3'd0,
    CFG_LOOK_DZ   = 3'd1,
    CFG_STICK_SEL = 3'd2,
    CFG_UPPER     = 3'd3,
    CFG_MODE      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_BOOL  = 2'd0,
    KIND_AXIS1 = 2'd1,
    KIND_AXIS2 = 2'd2,
    KIND_AXIS3 = 2'd3
  } kind_e;

endpackage

// ----- hdl/sdr_if.sv -----
// Valid/ready stream interfaces for stick samples and conditioned results.
// Depends on sdr_pkg for the axis width.
interface sdr_in_if import sdr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             value_kind;
  logic signed [AX_W-1:0] axis_x;
  logic signed [AX_W-1:0] axis_y;
  logic signed [AX_W-1:0] axis_z;

  modport source (output valid, value_kind, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, value_kind, axis_x, axis_y, axis_z, output ready);
endinterface

interface sdr_out_if import sdr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [AX_W-1:0] out_x;
  logic signed [AX_W-1:0] out_y;
  logic signed [AX_W-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- hdl/sdr_sqrt_cell.sv -----
// One digit step of the restoring integer square root, registered.
// Depends on sdr_pkg for the radicand and root widths.
module sdr_sqrt_cell import sdr_pkg::*; #(
  parameter int SW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [MAG_W-1:0] root_i,
  input  logic [SQ_W-1:0]  rad_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [REM_W-1:0] rem_o,
  output logic [MAG_W-1:0] root_o,
  output logic [SQ_W-1:0]  rad_o,
  output logic [SW-1:0]    side_o
);

  logic [REM_W+1:0] rem_ext;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;
  logic [REM_W-1:0] rem_d;
  logic [MAG_W-1:0] root_d;

  // bring down the next bit pair and try the trial subtrahend
  always_comb begin
    rem_ext = {rem_i, rad_i[SQ_W-1 -: 2]};
    trial   = {1'b0, root_i, 2'b01};
    diff    = rem_ext - trial;
    ge      = (rem_ext >= trial);
    rem_d   = ge ? diff[REM_W-1:0] : rem_ext[REM_W-1:0];
    root_d  = {root_i[MAG_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      rad_o  <= {rad_i[SQ_W-3:0], 2'b00};
      side_o <= side_i;
    end
  end

endmodule

// ----- hdl/sdr_div_cell.sv -----
// One quotient bit of a restoring division over several lanes sharing a divisor.
// Depends on sdr_pkg by convention only through its callers' widths.
module sdr_div_cell import sdr_pkg::*; #(
  parameter int LANES = 3,
  parameter int DW    = 16,
  parameter int QW    = 13,
  parameter int SW    = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][DW-1:0]  rem_i,
  input  logic [LANES-1:0][QW-1:0]  num_i,
  input  logic [LANES-1:0][QW-1:0]  quo_i,
  input  logic [DW-1:0]             den_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [LANES-1:0][DW-1:0]  rem_o,
  output logic [LANES-1:0][QW-1:0]  num_o,
  output logic [LANES-1:0][QW-1:0]  quo_o,
  output logic [DW-1:0]             den_o,
  output logic [SW-1:0]             side_o
);

  logic [LANES-1:0][DW:0]   r2;
  logic [LANES-1:0][DW:0]   sub;
  logic [LANES-1:0]         ge;
  logic [LANES-1:0][DW-1:0] rem_d;
  logic [LANES-1:0][QW-1:0] quo_d;

  // shift in the next numerator bit and subtract where it fits
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      r2[l]    = {rem_i[l], num_i[l][QW-1]};
      sub[l]   = r2[l] - {1'b0, den_i};
      ge[l]    = (r2[l] >= {1'b0, den_i});
      rem_d[l] = ge[l] ? sub[l][DW-1:0] : r2[l][DW-1:0];
      quo_d[l] = {quo_i[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_o[l] <= rem_d[l];
        num_o[l] <= {num_i[l][QW-2:0], 1'b0};
        quo_o[l] <= quo_d[l];
      end
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

// ----- hdl/sdr_skid.sv -----
// Output register with a one-entry skid so the pipeline sees a registered ready.
// Depends on sdr_pkg by convention; width is a parameter.
module sdr_skid import sdr_pkg::*; #(
  parameter int W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic         main_v_q, skid_v_q;
  logic [W-1:0] main_q, skid_q;
  logic         load_main;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;
  assign load_main   = out_ready_i || !main_v_q;

  // refill the main slot from the skid first; park a transfer when stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_main) begin
      main_v_q <= skid_v_q || in_valid_i;
      skid_v_q <= 1'b0;
    end else if (in_valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main) begin
      main_q <= skid_v_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_v_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule

// ----- hdl/stick_deadzone_rescale_core.sv -----
// Stick deadzone conditioner: one sample enters per cycle and one result leaves per cycle,
// while the consumer accepts results; the pipeline stalls when the output skid is full. The path is:
// two front stages, a 16-cell square root chain, a prep stage, a FRAC_BITS-cell divider chain
// for the deadzone ratio, two stages for the rescale product, a FRAC_BITS+1-cell divider chain
// for the radial scaling, and the output register. Configuration writes take effect on items
// accepted afterward. Depends on sdr_pkg, sdr_if, sdr_sqrt_cell, sdr_div_cell and sdr_skid.
module stick_deadzone_rescale_core import sdr_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sdr_in_if.sink               in_i,
  sdr_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int          V_W   = FRAC_BITS + 1;   // deadzone value, up to one
  localparam int          P_W   = AX_W + V_W;      // axis magnitude times value
  localparam logic [31:0] ONE_W = 32'd1 << FRAC_BITS;

  typedef struct packed {
    logic signed [AX_W-1:0] x;
    logic signed [AX_W-1:0] y;
    logic signed [AX_W-1:0] z;
    logic [CFG_W-1:0]       lo;
    logic [CFG_W-1:0]       hi;
    logic                   bypass;
    logic                   radial;
  } sq_side_t;

  typedef struct packed {
    logic signed [AX_W-1:0] x;
    logic signed [AX_W-1:0] y;
    logic signed [AX_W-1:0] z;
    logic                   bypass;
    logic                   radial;
    logic [MAG_W-1:0]       mag;
    logic [2:0]             zero;
    logic [2:0]             cap;
  } dz_side_t;

  typedef struct packed {
    logic [2:0]             neg;
    logic                   radial_nz;
    logic [2:0][AX_W-1:0]   pre;
  } sc_side_t;

  localparam int SQS_W = $bits(sq_side_t);
  localparam int DZS_W = $bits(dz_side_t);
  localparam int SCS_W = $bits(sc_side_t);

  function automatic logic [AX_W-1:0] sat16(input logic signed [31:0] v);
    logic [AX_W-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'h7fff;
    end else if (v < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[AX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [AX_W-1:0] abs16(input logic signed [AX_W-1:0] a);
    return a[AX_W-1] ? AX_W'(-a) : a;
  endfunction

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] move_dz_q, look_dz_q, upper_q;
  logic             stick_sel_q, mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_dz_q   <= DZ_RESET;
      look_dz_q   <= DZ_RESET;
      stick_sel_q <= 1'b0;
      upper_q     <= UPPER_RESET;
      mode_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MOVE_DZ:   move_dz_q   <= cfg_data_i;
        CFG_LOOK_DZ:   look_dz_q   <= cfg_data_i;
        CFG_STICK_SEL: stick_sel_q <= cfg_data_i[0];
        CFG_UPPER:     upper_q     <= cfg_data_i;
        CFG_MODE:      mode_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic skid_ready;

  assign en       = skid_ready;
  assign in_i.ready = en;

  // ---------------------------------------------------------------- stage 1
  kind_e            kind;
  logic [CFG_W-1:0] lo_sel;
  logic             s1_valid_q;
  sq_side_t         s1_q;

  assign kind   = kind_e'(in_i.value_kind);
  assign lo_sel = stick_sel_q ? look_dz_q : move_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // capture the sample, drop unused axes and clamp the lower threshold
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.x      <= in_i.axis_x;
      s1_q.y      <= (kind == KIND_AXIS1) ? '0 : in_i.axis_y;
      s1_q.z      <= (kind == KIND_AXIS1 || kind == KIND_AXIS2) ? '0 : in_i.axis_z;
      s1_q.lo     <= (32'(lo_sel) > ONE_W) ? ONE_W[CFG_W-1:0] : lo_sel;
      s1_q.hi     <= upper_q;
      s1_q.bypass <= (kind == KIND_BOOL);
      s1_q.radial <= mode_q && (kind == KIND_AXIS2 || kind == KIND_AXIS3);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [2*AX_W-1:0] px, py, pz;
  logic                     s2_valid_q;
  logic [2:0][SQ_W-2:0]     s2_sq_q;
  sq_side_t                 s2_q;

  assign px = s1_q.x * s1_q.x;
  assign py = s1_q.y * s1_q.y;
  assign pz = s1_q.z * s1_q.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // square each axis
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sq_q[0] <= px[SQ_W-2:0];
      s2_sq_q[1] <= py[SQ_W-2:0];
      s2_sq_q[2] <= pz[SQ_W-2:0];
      s2_q       <= s1_q;
    end
  end

  // ---------------------------------------------------------------- square root chain
  logic             sq_valid [0:MAG_W];
  logic [REM_W-1:0] sq_rem   [0:MAG_W];
  logic [MAG_W-1:0] sq_root  [0:MAG_W];
  logic [SQ_W-1:0]  sq_rad   [0:MAG_W];
  logic [SQS_W-1:0] sq_side  [0:MAG_W];

  assign sq_valid[0] = s2_valid_q;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_rad[0]   = SQ_W'(s2_sq_q[0]) + SQ_W'(s2_sq_q[1]) + SQ_W'(s2_sq_q[2]);
  assign sq_side[0]  = s2_q;

  for (genvar i = 0; i < MAG_W; i++) begin : g_sqrt
    sdr_sqrt_cell #(.SW(SQS_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .rad_i   (sq_rad[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_valid[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .rad_o   (sq_rad[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // ---------------------------------------------------------------- stage 4: deadzone prep
  sq_side_t                   sq_end;
  logic [MAG_W-1:0]           mag;
  logic signed [AX_W-1:0]     ax [3];
  logic [2:0][AX_W-1:0]       lane_m;
  logic signed [AX_W:0]       diff [3];
  logic signed [AX_W:0]       span;
  logic                       span_pos;
  logic [2:0]                 lane_zero, lane_cap;
  logic [2:0][CFG_W-1:0]      lane_rem;

  assign sq_end = sq_side[MAG_W];
  assign mag    = sq_root[MAG_W];
  assign ax[0]  = sq_end.x;
  assign ax[1]  = sq_end.y;
  assign ax[2]  = sq_end.z;

  // subtract the lower threshold and flag values under it or past the span
  always_comb begin
    span     = $signed({2'b00, sq_end.hi}) - $signed({2'b00, sq_end.lo});
    span_pos = (span > 0);
    for (int k = 0; k < 3; k++) begin
      if (sq_end.radial) begin
        lane_m[k] = (k == 0) ? mag : '0;
      end else begin
        lane_m[k] = abs16(ax[k]);
      end
      diff[k]      = $signed({1'b0, lane_m[k]}) - $signed({2'b00, sq_end.lo});
      lane_zero[k] = (diff[k] <= 0);
      lane_cap[k]  = !span_pos || (diff[k] >= span);
      lane_rem[k]  = (lane_zero[k] || lane_cap[k]) ? '0 : diff[k][CFG_W-1:0];
    end
  end

  logic                       s4_valid_q;
  logic [2:0][CFG_W-1:0]      s4_rem_q;
  logic [CFG_W-1:0]           s4_den_q;
  dz_side_t                   s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= sq_valid[MAG_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_rem_q    <= lane_rem;
      s4_den_q    <= span_pos ? span[CFG_W-1:0] : '0;
      s4_q.x      <= sq_end.x;
      s4_q.y      <= sq_end.y;
      s4_q.z      <= sq_end.z;
      s4_q.bypass <= sq_end.bypass;
      s4_q.radial <= sq_end.radial;
      s4_q.mag    <= mag;
      s4_q.zero   <= lane_zero;
      s4_q.cap    <= lane_cap;
    end
  end

  // ---------------------------------------------------------------- ratio divider chain
  logic                          d1_valid [0:FRAC_BITS];
  logic [2:0][CFG_W-1:0]         d1_rem   [0:FRAC_BITS];
  logic [2:0][FRAC_BITS-1:0]     d1_num   [0:FRAC_BITS];
  logic [2:0][FRAC_BITS-1:0]     d1_quo   [0:FRAC_BITS];
  logic [CFG_W-1:0]              d1_den   [0:FRAC_BITS];
  logic [DZS_W-1:0]              d1_side  [0:FRAC_BITS];

  assign d1_valid[0] = s4_valid_q;
  assign d1_rem[0]   = s4_rem_q;
  assign d1_num[0]   = '0;
  assign d1_quo[0]   = '0;
  assign d1_den[0]   = s4_den_q;
  assign d1_side[0]  = s4_q;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div1
    sdr_div_cell #(.LANES(3), .DW(CFG_W), .QW(FRAC_BITS), .SW(DZS_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d1_valid[i]),
      .rem_i   (d1_rem[i]),
      .num_i   (d1_num[i]),
      .quo_i   (d1_quo[i]),
      .den_i   (d1_den[i]),
      .side_i  (d1_side[i]),
      .valid_o (d1_valid[i+1]),
      .rem_o   (d1_rem[i+1]),
      .num_o   (d1_num[i+1]),
      .quo_o   (d1_quo[i+1]),
      .den_o   (d1_den[i+1]),
      .side_o  (d1_side[i+1])
    );
  end

  // ---------------------------------------------------------------- stage 5: deadzone value
  dz_side_t               d1_end;
  logic [2:0][V_W-1:0]    v;
  logic signed [AX_W-1:0] bx [3];
  logic [2:0][AX_W-1:0]   pre;
  logic signed [31:0]     sv;

  assign d1_end = d1_side[FRAC_BITS];
  assign bx[0]  = d1_end.x;
  assign bx[1]  = d1_end.y;
  assign bx[2]  = d1_end.z;

  // pick zero, full scale or the quotient; finish bypass and axial results here
  always_comb begin
    sv = '0;
    for (int k = 0; k < 3; k++) begin
      if (d1_end.zero[k]) begin
        v[k] = '0;
      end else if (d1_end.cap[k]) begin
        v[k] = ONE_W[V_W-1:0];
      end else begin
        v[k] = {1'b0, d1_quo[FRAC_BITS][k]};
      end
      sv = bx[k][AX_W-1] ? -$signed(32'(v[k])) : $signed(32'(v[k]));
      if (d1_end.bypass) begin
        pre[k] = bx[k];
      end else if (d1_end.radial) begin
        pre[k] = '0;
      end else begin
        pre[k] = sat16(sv);
      end
    end
  end

  logic                 s5_valid_q;
  logic [V_W-1:0]       s5_v0_q;
  logic [2:0][AX_W-1:0] s5_ax_q;
  logic [MAG_W-1:0]     s5_mag_q;
  sc_side_t             s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= d1_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_v0_q        <= v[0];
      s5_ax_q[0]     <= d1_end.x;
      s5_ax_q[1]     <= d1_end.y;
      s5_ax_q[2]     <= d1_end.z;
      s5_mag_q       <= d1_end.mag;
      s5_q.neg       <= {d1_end.z[AX_W-1], d1_end.y[AX_W-1], d1_end.x[AX_W-1]};
      s5_q.radial_nz <= d1_end.radial && (d1_end.mag != '0);
      s5_q.pre       <= pre;
    end
  end

  // ---------------------------------------------------------------- stage 6: rescale product
  logic                 s6_valid_q;
  logic [2:0][P_W-1:0]  s6_p_q;
  logic [MAG_W-1:0]     s6_mag_q;
  sc_side_t             s6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en) begin
      s6_valid_q <= s5_valid_q;
    end
  end

  // scale each axis magnitude by the radial deadzone value
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s6_p_q[k] <= P_W'(abs16(s5_ax_q[k])) * P_W'(s5_v0_q);
      end
      s6_mag_q <= s5_mag_q;
      s6_q     <= s5_q;
    end
  end

  // ---------------------------------------------------------------- radial divider chain
  logic                    d2_valid [0:V_W];
  logic [2:0][MAG_W-1:0]   d2_rem   [0:V_W];
  logic [2:0][V_W-1:0]     d2_num   [0:V_W];
  logic [2:0][V_W-1:0]     d2_quo   [0:V_W];
  logic [MAG_W-1:0]        d2_den   [0:V_W];
  logic [SCS_W-1:0]        d2_side  [0:V_W];

  assign d2_valid[0] = s6_valid_q;
  assign d2_quo[0]   = '0;
  assign d2_den[0]   = s6_mag_q;
  assign d2_side[0]  = s6_q;

  // the quotient stays within V_W bits, so the upper product bits start the remainder
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d2_rem[0][k] = s6_p_q[k][P_W-1 -: MAG_W];
      d2_num[0][k] = s6_p_q[k][V_W-1:0];
    end
  end

  for (genvar i = 0; i < V_W; i++) begin : g_div2
    sdr_div_cell #(.LANES(3), .DW(MAG_W), .QW(V_W), .SW(SCS_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d2_valid[i]),
      .rem_i   (d2_rem[i]),
      .num_i   (d2_num[i]),
      .quo_i   (d2_quo[i]),
      .den_i   (d2_den[i]),
      .side_i  (d2_side[i]),
      .valid_o (d2_valid[i+1]),
      .rem_o   (d2_rem[i+1]),
      .num_o   (d2_num[i+1]),
      .quo_o   (d2_quo[i+1]),
      .den_o   (d2_den[i+1]),
      .side_o  (d2_side[i+1])
    );
  end

  // ---------------------------------------------------------------- result
  sc_side_t             d2_end;
  logic [2:0][AX_W-1:0] res;
  logic signed [31:0]   sq;

  assign d2_end = d2_side[V_W];

  // apply the sign to the radial quotient, or keep the finished result
  always_comb begin
    sq = '0;
    for (int k = 0; k < 3; k++) begin
      sq = d2_end.neg[k] ? -$signed(32'(d2_quo[V_W][k])) : $signed(32'(d2_quo[V_W][k]));
      res[k] = d2_end.radial_nz ? sat16(sq) : d2_end.pre[k];
    end
  end

  logic [3*AX_W-1:0] out_data;

  sdr_skid #(.W(3*AX_W)) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d2_valid[V_W]),
    .in_ready_o  (skid_ready),
    .in_data_i   ({res[0], res[1], res[2]}),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.out_x = out_data[3*AX_W-1 -: AX_W];
  assign out_o.out_y = out_data[2*AX_W-1 -: AX_W];
  assign out_o.out_z = out_data[AX_W-1:0];

endmodule
